### design/hall_sensor_position_tracker_top_assert.svh
// ---------------------------------------------------------------------------
// Hall sensor position tracker assertion macros
// Concurrent assertion helpers shared by the tracker RTL.
// ---------------------------------------------------------------------------
`ifndef HALL_SENSOR_POSITION_TRACKER_TOP_ASSERT_SVH
`define HALL_SENSOR_POSITION_TRACKER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define HSPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define HSPT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSPT_ASSERT(lbl, prop, msg)
`define HSPT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### design/hspt_pkg.sv
// ---------------------------------------------------------------------------
// Hall sensor position tracker package
// Widths, codes and small lookup functions shared by the tracker.
// ---------------------------------------------------------------------------
package hspt_pkg;

    // Timer and arithmetic widths.
    localparam int TIMER_WIDTH = 16;
    localparam int TURN_W      = 15;
    localparam int PROD_W      = TIMER_WIDTH + TURN_W;
    localparam int QUOT_W      = 14;
    localparam int DELTA_W     = QUOT_W - 1;
    localparam int CNT_W       = $clog2(QUOT_W);
    localparam int ANGLE_W     = 16;

    typedef logic [TIMER_WIDTH-1:0] timer_t;
    typedef logic [DELTA_W-1:0]     delta_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    localparam timer_t            TIMER_MAX  = '1;
    localparam logic [TURN_W-1:0] TURN_UNITS = TURN_W'(23040);
    localparam delta_t            SEG_UNITS  = DELTA_W'(3840);

    // Request kinds.
    localparam logic [1:0] KIND_EDGE     = 2'd0;
    localparam logic [1:0] KIND_ROLLOVER = 2'd1;
    localparam logic [1:0] KIND_QUERY    = 2'd2;

    // Direction codes.
    localparam logic [1:0] DIR_UNKNOWN = 2'd0;
    localparam logic [1:0] DIR_FORWARD = 2'd1;
    localparam logic [1:0] DIR_REVERSE = 2'd2;

    // Segment codes.
    localparam logic [2:0] SEG_LAST = 3'd5;
    localparam logic [2:0] NO_SEG   = 3'd7;
    localparam logic [2:0] STEP_MAX = 3'd6;

    // UVW hall code to 60-degree segment; two codes are invalid.
    function automatic logic [2:0] seg_map(input logic [2:0] code);
        logic [2:0] seg;
        unique case (code)
            3'b000:  seg = 3'd0;
            3'b001:  seg = 3'd1;
            3'b011:  seg = 3'd2;
            3'b111:  seg = 3'd3;
            3'b110:  seg = 3'd4;
            3'b100:  seg = 3'd5;
            default: seg = NO_SEG;
        endcase
        return seg;
    endfunction

    // Following segment, wrapping after the last one.
    function automatic logic [2:0] next_seg(input logic [2:0] seg);
        return (seg == SEG_LAST) ? 3'd0 : seg + 3'd1;
    endfunction

    // Start angle of a segment in 1/64 degree.
    function automatic angle_t seg_base(input logic [2:0] seg);
        angle_t base;
        unique case (seg)
            3'd0:    base = ANGLE_W'(0);
            3'd1:    base = ANGLE_W'(3840);
            3'd2:    base = ANGLE_W'(7680);
            3'd3:    base = ANGLE_W'(11520);
            3'd4:    base = ANGLE_W'(15360);
            3'd5:    base = ANGLE_W'(19200);
            default: base = ANGLE_W'(0);
        endcase
        return base;
    endfunction

    // Interpolated angle from segment, direction and offset into the segment.
    function automatic angle_t calc_angle(input logic [2:0] seg, input logic [1:0] dir,
                                          input delta_t delta);
        angle_t ang;
        angle_t d;
        d = angle_t'(delta);
        if (dir == DIR_REVERSE) begin
            ang = seg_base(next_seg(seg)) - d;
        end else if (dir == DIR_FORWARD || dir == DIR_UNKNOWN) begin
            ang = seg_base(seg) + d;
        end else begin
            ang = '0;
        end
        return ang;
    endfunction

endpackage

### design/hall_sensor_position_tracker_top.sv
// ---------------------------------------------------------------------------
// Hall sensor position tracker
// Hall code decoding, direction and period tracking, and angle interpolation.
// ---------------------------------------------------------------------------
// Usage:
// One input channel (in_valid/in_ready) carries a request of one of three
// kinds: a hall edge with its capture time, a timer rollover, or a position
// query with the current timer count. Each request gives exactly one result
// on the output channel (out_valid/out_ready) that reports the state after it.
// Edges, rollovers and unused kinds finish fast: they go from idle straight to
// the output step, and out_valid rises once the output register takes the result.
// A query that needs interpolation runs one subtraction, one multiply and a
// 14-step restoring division on a single subtractor, passing through the
// multiply, divide, finish and output steps; queries that need no division
// take the fast path. in_ready is high only when idle.
// A finished result sits in the output register, so a new request may be
// accepted while it waits; a stalled receiver holds the block in its final
// step until the output register frees up.
// Reset clears the segment, direction, step counts and timing state; the
// block accepts requests in the first cycle after reset is released.
// ---------------------------------------------------------------------------
`include "hall_sensor_position_tracker_top_assert.svh"

module hall_sensor_position_tracker_top
    import hspt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             kind,
    input  logic [2:0]             hall_code,
    input  logic [TIMER_WIDTH-1:0] capture_time,
    input  logic [TIMER_WIDTH-1:0] timer_now,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   segment_known,
    output logic [2:0]             segment,
    output logic [1:0]             direction,
    output logic [TIMER_WIDTH-1:0] period,
    output logic signed [ANGLE_W-1:0] angle,
    output logic                   fault,
    output logic                   restart_timer
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    // Tracker state.
    state_t             state_reg;
    logic [2:0]         last_seg_reg;
    logic               seg_valid_reg;
    logic [1:0]         dir_reg;
    logic [2:0]         fwd_reg;
    logic [2:0]         bwd_reg;
    logic               timing_valid_reg;
    timer_t             period_reg;
    timer_t             last_edge_reg;

    // Per-request result and division datapath.
    angle_t             angle_reg;
    logic               fault_reg;
    logic               restart_reg;
    timer_t             elapsed_reg;
    logic [PROD_W-1:0]  rem_reg;
    logic [PROD_W-1:0]  div_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // Output register.
    logic               out_valid_reg;
    logic               out_known_reg;
    logic [2:0]         out_seg_reg;
    logic [1:0]         out_dir_reg;
    timer_t             out_period_reg;
    angle_t             out_angle_reg;
    logic               out_fault_reg;
    logic               out_restart_reg;

    // Edge update values.
    logic [2:0]         seg_code;
    logic [2:0]         last_seg_next;
    logic               seg_valid_next;
    logic [1:0]         dir_next;
    logic [2:0]         fwd_next;
    logic [2:0]         bwd_next;
    logic               timing_valid_next;
    timer_t             period_next;
    timer_t             last_edge_next;
    logic               fault_next;
    logic               restart_next;

    // Division step and final delta.
    logic               div_ge;
    logic [PROD_W-1:0]  prod;
    delta_t             delta_div;

    logic               in_fire;
    logic               out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Hall edge: segment tracking, step counting and period latching.
    always_comb
    begin
        seg_code          = seg_map(hall_code);
        last_seg_next     = last_seg_reg;
        seg_valid_next    = seg_valid_reg;
        dir_next          = dir_reg;
        fwd_next          = fwd_reg;
        bwd_next          = bwd_reg;
        timing_valid_next = timing_valid_reg;
        fault_next        = 1'b0;
        restart_next      = 1'b0;
        last_edge_next    = capture_time;

        if (seg_code == NO_SEG) begin
            seg_valid_next = 1'b0;
            dir_next       = DIR_UNKNOWN;
            fault_next     = 1'b1;
        end else if (!seg_valid_reg) begin
            last_seg_next  = seg_code;
            seg_valid_next = 1'b1;
            fwd_next       = '0;
            bwd_next       = '0;
        end else if (next_seg(last_seg_reg) == seg_code) begin
            dir_next      = DIR_FORWARD;
            last_seg_next = seg_code;
            fwd_next      = fwd_reg + 3'd1;
            bwd_next      = '0;
        end else if (next_seg(seg_code) == last_seg_reg) begin
            dir_next      = DIR_REVERSE;
            last_seg_next = seg_code;
            bwd_next      = bwd_reg + 3'd1;
            fwd_next      = '0;
        end else if (seg_code != last_seg_reg) begin
            seg_valid_next = 1'b0;
            dir_next       = DIR_UNKNOWN;
            fault_next     = 1'b1;
        end

        // A stopped period restarts at the timer maximum; a change of direction drops it.
        period_next = (period_reg == '0) ? TIMER_MAX : period_reg;
        if (dir_next != dir_reg) begin
            period_next = '0;
        end

        // Six steps in one direction close one electrical period.
        if (fwd_next >= STEP_MAX || bwd_next >= STEP_MAX) begin
            period_next       = timing_valid_reg ? capture_time : TIMER_MAX;
            timing_valid_next = 1'b1;
            last_edge_next    = '0;
            fwd_next          = '0;
            bwd_next          = '0;
            restart_next      = 1'b1;
        end
    end

    // Multiply, restoring-division compare, and the final delta.
    assign prod      = PROD_W'(elapsed_reg) * PROD_W'(TURN_UNITS);
    assign div_ge    = (rem_reg >= div_reg);
    assign delta_div = (quot_reg > QUOT_W'(SEG_UNITS)) ? SEG_UNITS : quot_reg[DELTA_W-1:0];

    // Sequencer with state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            last_seg_reg     <= '0;
            seg_valid_reg    <= 1'b0;
            dir_reg          <= DIR_UNKNOWN;
            fwd_reg          <= '0;
            bwd_reg          <= '0;
            timing_valid_reg <= 1'b0;
            period_reg       <= '0;
            last_edge_reg    <= '0;
            angle_reg        <= '0;
            fault_reg        <= 1'b0;
            restart_reg      <= 1'b0;
            elapsed_reg      <= '0;
            rem_reg          <= '0;
            div_reg          <= '0;
            quot_reg         <= '0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            out_known_reg    <= 1'b0;
            out_seg_reg      <= '0;
            out_dir_reg      <= DIR_UNKNOWN;
            out_period_reg   <= '0;
            out_angle_reg    <= '0;
            out_fault_reg    <= 1'b0;
            out_restart_reg  <= 1'b0;
        end else begin
            // The final step refills the output register itself.
            if (out_valid_reg && out_ready && state_reg != S_OUT) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire) begin
                        unique case (kind)
                            KIND_EDGE:
                            begin
                                last_seg_reg     <= last_seg_next;
                                seg_valid_reg    <= seg_valid_next;
                                dir_reg          <= dir_next;
                                fwd_reg          <= fwd_next;
                                bwd_reg          <= bwd_next;
                                timing_valid_reg <= timing_valid_next;
                                period_reg       <= period_next;
                                last_edge_reg    <= last_edge_next;
                                fault_reg        <= fault_next;
                                restart_reg      <= restart_next;
                                angle_reg        <= '0;
                                state_reg        <= S_OUT;
                            end
                            KIND_ROLLOVER:
                            begin
                                timing_valid_reg <= 1'b0;
                                period_reg       <= '0;
                                angle_reg        <= '0;
                                fault_reg        <= 1'b0;
                                restart_reg      <= 1'b0;
                                state_reg        <= S_OUT;
                            end
                            KIND_QUERY:
                            begin
                                fault_reg   <= 1'b0;
                                restart_reg <= 1'b0;
                                if (!seg_valid_reg) begin
                                    angle_reg <= '0;
                                    state_reg <= S_OUT;
                                end else if (period_reg == '0) begin
                                    angle_reg <= calc_angle(last_seg_reg, dir_reg, '0);
                                    state_reg <= S_OUT;
                                end else if (timer_now < last_edge_reg) begin
                                    angle_reg <= calc_angle(last_seg_reg, dir_reg, SEG_UNITS);
                                    state_reg <= S_OUT;
                                end else begin
                                    elapsed_reg <= timer_now - last_edge_reg;
                                    state_reg   <= S_MULT;
                                end
                            end
                            default:
                            begin
                                // Unused kind only reports the state.
                                angle_reg   <= '0;
                                fault_reg   <= 1'b0;
                                restart_reg <= 1'b0;
                                state_reg   <= S_OUT;
                            end
                        endcase
                    end
                end
                S_MULT:
                begin
                    rem_reg   <= prod;
                    div_reg   <= PROD_W'(period_reg) << (QUOT_W - 1);
                    quot_reg  <= '0;
                    cnt_reg   <= CNT_W'(QUOT_W - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // One quotient bit per cycle, most significant first.
                    if (div_ge) begin
                        rem_reg <= rem_reg - div_reg;
                    end
                    div_reg  <= div_reg >> 1;
                    quot_reg <= {quot_reg[QUOT_W-2:0], div_ge};
                    cnt_reg  <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    angle_reg <= calc_angle(last_seg_reg, dir_reg, delta_div);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free) begin
                        out_valid_reg   <= 1'b1;
                        out_known_reg   <= seg_valid_reg;
                        out_seg_reg     <= seg_valid_reg ? last_seg_reg : 3'd0;
                        out_dir_reg     <= dir_reg;
                        out_period_reg  <= period_reg;
                        out_angle_reg   <= angle_reg;
                        out_fault_reg   <= fault_reg;
                        out_restart_reg <= restart_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign segment_known = out_known_reg;
    assign segment       = out_seg_reg;
    assign direction     = out_dir_reg;
    assign period        = out_period_reg;
    assign angle         = out_angle_reg;
    assign fault         = out_fault_reg;
    assign restart_timer = out_restart_reg;

    // Only one request is in flight at a time.
    `HSPT_ASSERT(a_one_in_flight, in_fire |=> !in_ready, "request accepted while busy")
    // A skipped or invalid edge can never complete a period.
    `HSPT_ASSERT(a_fault_no_restart, out_valid |-> !(fault && restart_timer), "fault with restart")
    // Division only runs against a nonzero period.
    `HSPT_ASSERT(a_div_period, state_reg == S_DIV |-> period_reg != '0, "division by zero period")
    // A period latch restarts the edge time base.
    `HSPT_ASSERT_ALWAYS(a_restart_edge, state_reg == S_OUT && restart_reg |-> last_edge_reg == '0,
        "edge time kept after restart")

endmodule
